/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the shelf_rect_allocator design
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// expression that must never hold
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

/* design/sra_pkg.sv */
// ---------------------------------------------------------------------------
// sra_pkg
// Types and constants of the shelf rectangle allocator.
// ---------------------------------------------------------------------------
package sra_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_SPANS = 16;
  localparam int ROW_AW    = $clog2(MAX_ROWS);
  localparam int SPAN_IW   = $clog2(MAX_SPANS);
  localparam int SPAN_AW   = ROW_AW + SPAN_IW;
  localparam int SPAN_DEPTH = MAX_ROWS * MAX_SPANS;

  localparam logic [15:0] GROW_LIMIT = 16'd4;
  localparam logic [15:0] RST_DIM    = 16'd1024;

  localparam logic REG_ATLAS_W = 1'b0;
  localparam logic REG_ATLAS_H = 1'b1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] item_width;
    logic [15:0] item_height;
    logic [15:0] item_left;
    logic [15:0] item_top;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] rect_left;
    logic [15:0] rect_top;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
  } rsp_t;

  typedef struct packed {
    logic [15:0] height;
    logic [15:0] widest;
    logic [4:0]  cnt;
  } row_t;

  typedef struct packed {
    logic [15:0] le;
    logic [15:0] re;
  } span_t;

  typedef enum logic [4:0] {
    S_IDLE,
    A_ROW_RD,
    A_ROW_CHK,
    A_PLACE,
    SP_RD,
    SP_CHK,
    SP_CARVE,
    A_CHKMAX,
    MX_RD,
    MX_CHK,
    A_WB,
    RM_RD,
    RM_WR,
    F_ROW_RD,
    F_ROW_ADV,
    F_ROW_GOT,
    F_SP_RD,
    F_SP_CHK,
    F_MERGE,
    IN_RD,
    IN_WR,
    F_FIN,
    POP_RD,
    POP_CHK,
    S_OK,
    S_FAIL
  } state_t;

endpackage

/* design/shelf_rect_allocator.sv */
// Allocate: scans the rows, then the row's spans; rescans the spans when the widest span is used.
// Free: scans the rows, then the row's spans; shifts spans on insert or remove; pops empty last rows.
// One item at a time; each scan step is one read of the row or span memory and one compare.
// The result is shown for one cycle with done; the receiver cannot stall.
// Synchronous reset: 1024 x 1024 atlas, no rows; memories are not cleared.
// ---------------------------------------------------------------------------
// shelf_rect_allocator
// Shelf allocator for a 2D atlas with a row table and per-row free span lists.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module shelf_rect_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sra_pkg::req_t req,
  output logic          done,
  output sra_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import sra_pkg::*;

  state_t state, state_next;

  logic [15:0] aw, ah, rem;
  logic [6:0]  row_count;
  req_t        rq;
  logic [6:0]  rptr;
  logic [15:0] top, btop, match, bw, bl, br, lft, rgt, mx;
  logic        found, sfound;
  logic [ROW_AW-1:0]  best;
  logic [SPAN_IW-1:0] bspan, prev;
  logic [4:0]  sptr;
  row_t        lastq, cur;
  span_t       prevq, itq;

  row_t  row_mem [MAX_ROWS];
  span_t span_mem [SPAN_DEPTH];
  row_t  row_q, row_wdata;
  span_t span_q, span_wdata;
  logic  row_we, span_we;
  logic [ROW_AW-1:0]  row_raddr, row_waddr;
  logic [SPAN_AW-1:0] span_raddr, span_waddr;

  logic [15:0] w, h, sw, diff, merge_r, fin_d, fin_wf;
  logic        hit, grow_ok, itv, c1, itfit;
  logic [6:0]  row_cnt_m1;
  logic [4:0]  sptr_p1, sptr_m1;
  logic        cfg_we;

  assign w          = rq.item_width;
  assign h          = rq.item_height;
  assign sw         = span_q.re - span_q.le;
  assign hit        = row_q.widest >= w && row_q.height >= h &&
                      (!found || row_q.height < match);
  assign diff       = h - lastq.height;
  assign grow_ok    = row_count != 7'd0 && lastq.widest >= w &&
                      (diff <= GROW_LIMIT || rem < h) && diff <= rem;
  assign itv        = sptr < cur.cnt;
  assign c1         = cur.cnt != 5'd0 && prevq.re == lft;
  assign itfit      = itv && itq.le == rgt;
  assign merge_r    = itfit ? itq.re : rgt;
  assign fin_d      = rgt - lft;
  assign fin_wf     = (fin_d > cur.widest) ? fin_d : cur.widest;
  assign row_cnt_m1 = row_count - 7'd1;
  assign sptr_p1    = sptr + 5'd1;
  assign sptr_m1    = sptr - 5'd1;
  assign busy       = state != S_IDLE;
  assign cfg_we     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_ATLAS_H) ? {16'd0, ah} : {16'd0, aw};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (req.item_width == 16'd0 || req.item_height == 16'd0) state_next = S_FAIL;
          else if (req.req_type == REQ_ALLOC) state_next = A_ROW_RD;
          else state_next = F_ROW_RD;
        end
      end
      A_ROW_RD:  state_next = (rptr == row_count) ? A_PLACE : A_ROW_CHK;
      A_ROW_CHK: state_next = (hit && row_q.height == h) ? A_PLACE : A_ROW_RD;
      A_PLACE: begin
        if (found || grow_ok) state_next = SP_RD;
        else if (rem < h || row_count >= 7'(MAX_ROWS) || aw < w) state_next = S_FAIL;
        else state_next = SP_RD;
      end
      SP_RD:    state_next = (sptr == cur.cnt) ? SP_CARVE : SP_CHK;
      SP_CHK:   state_next = SP_RD;
      SP_CARVE: state_next = (bw == w) ? RM_RD : A_CHKMAX;
      A_CHKMAX: state_next = (bw == cur.widest) ? MX_RD : A_WB;
      MX_RD:    state_next = (sptr == cur.cnt) ? A_WB : MX_CHK;
      MX_CHK:   state_next = MX_RD;
      A_WB:     state_next = S_IDLE;
      RM_RD: begin
        if (sptr_p1 < cur.cnt) state_next = RM_WR;
        else if (rq.req_type == REQ_FREE) state_next = F_FIN;
        else state_next = A_CHKMAX;
      end
      RM_WR: state_next = RM_RD;
      F_ROW_RD: begin
        if (rptr >= row_count) state_next = S_FAIL;
        else if (top != rq.item_top) state_next = F_ROW_ADV;
        else state_next = F_ROW_GOT;
      end
      F_ROW_ADV: state_next = F_ROW_RD;
      F_ROW_GOT: state_next = F_SP_RD;
      F_SP_RD:   state_next = itv ? F_SP_CHK : F_MERGE;
      F_SP_CHK:  state_next = (span_q.re <= lft) ? F_SP_RD : F_MERGE;
      F_MERGE: begin
        if (c1) state_next = itfit ? RM_RD : F_FIN;
        else if (itfit) state_next = F_FIN;
        else if (cur.cnt >= 5'(MAX_SPANS)) state_next = S_FAIL;
        else state_next = IN_RD;
      end
      IN_RD:   state_next = (sptr > {1'b0, bspan}) ? IN_WR : F_FIN;
      IN_WR:   state_next = IN_RD;
      F_FIN:   state_next = (fin_wf == aw && {1'b0, best} + 7'd1 == row_count) ? POP_RD : S_OK;
      POP_RD:  state_next = (row_count != 7'd0) ? POP_CHK : S_OK;
      POP_CHK: state_next = (row_q.widest == aw) ? POP_RD : S_OK;
      S_OK:    state_next = S_IDLE;
      S_FAIL:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory ports
  always_comb begin
    row_raddr  = rptr[ROW_AW-1:0];
    row_we     = 1'b0;
    row_waddr  = best;
    row_wdata  = cur;
    span_raddr = {best, sptr[SPAN_IW-1:0]};
    span_we    = 1'b0;
    span_waddr = {best, bspan};
    span_wdata = '{le: bl, re: br};
    unique case (state)
      A_PLACE: begin
        if (!found && !grow_ok) begin
          span_we    = !(rem < h || row_count >= 7'(MAX_ROWS) || aw < w);
          span_waddr = {row_count[ROW_AW-1:0], {SPAN_IW{1'b0}}};
          span_wdata = '{le: 16'd0, re: aw};
        end
      end
      SP_CARVE: begin
        span_we = bw != w;
        if (br == aw) span_wdata = '{le: bl, re: br - w};
        else span_wdata = '{le: bl + w, re: br};
      end
      A_WB: row_we = 1'b1;
      RM_RD: span_raddr = {best, sptr_p1[SPAN_IW-1:0]};
      RM_WR: begin
        span_we    = 1'b1;
        span_waddr = {best, sptr[SPAN_IW-1:0]};
        span_wdata = span_q;
      end
      F_MERGE: begin
        if (c1) begin
          span_we    = 1'b1;
          span_waddr = {best, prev};
          span_wdata = '{le: prevq.le, re: merge_r};
        end else if (itfit) begin
          span_we    = 1'b1;
          span_waddr = {best, sptr[SPAN_IW-1:0]};
          span_wdata = '{le: lft, re: itq.re};
        end
      end
      IN_RD: begin
        span_raddr = {best, sptr_m1[SPAN_IW-1:0]};
        if (!(sptr > {1'b0, bspan})) begin
          span_we    = 1'b1;
          span_waddr = {best, bspan};
          span_wdata = '{le: lft, re: rgt};
        end
      end
      IN_WR: begin
        span_we    = 1'b1;
        span_waddr = {best, sptr[SPAN_IW-1:0]};
        span_wdata = span_q;
      end
      F_FIN: begin
        row_we    = 1'b1;
        row_wdata = '{height: cur.height, widest: fin_wf, cnt: cur.cnt};
      end
      POP_RD: row_raddr = row_cnt_m1[ROW_AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    row_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (span_we) span_mem[span_waddr] <= span_wdata;
    span_q <= span_mem[span_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      aw        <= RST_DIM;
      ah        <= RST_DIM;
      rem       <= RST_DIM;
      row_count <= 7'd0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        A_PLACE: begin
          if (!found && grow_ok) rem <= rem - diff;
          else if (!found && !(rem < h || row_count >= 7'(MAX_ROWS) || aw < w)) begin
            rem       <= rem - h;
            row_count <= row_count + 7'd1;
          end
        end
        A_WB, S_OK, S_FAIL: done <= 1'b1;
        F_FIN: begin
          if (fin_wf == aw && {1'b0, best} + 7'd1 == row_count) begin
            rem       <= rem + cur.height;
            row_count <= row_cnt_m1;
          end
        end
        POP_CHK: begin
          if (row_q.widest == aw) begin
            rem       <= rem + row_q.height;
            row_count <= row_cnt_m1;
          end
        end
        default: ;
      endcase
      if (cfg_we) begin
        row_count <= 7'd0;
        if (paddr[2] == REG_ATLAS_H) begin
          ah  <= pwdata[15:0];
          rem <= pwdata[15:0];
        end else begin
          aw  <= pwdata[15:0];
          rem <= ah;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        rq     <= req;
        rptr   <= 7'd0;
        top    <= 16'd0;
        found  <= 1'b0;
      end
      A_ROW_CHK: begin
        lastq <= row_q;
        top   <= top + row_q.height;
        rptr  <= rptr + 7'd1;
        if (hit) begin
          found <= 1'b1;
          best  <= rptr[ROW_AW-1:0];
          btop  <= top;
          match <= row_q.height;
          cur   <= row_q;
        end
      end
      A_PLACE: begin
        sptr   <= 5'd0;
        sfound <= 1'b0;
        if (!found) begin
          if (grow_ok) begin
            btop <= top - lastq.height;
            best <= row_cnt_m1[ROW_AW-1:0];
            cur  <= '{height: h, widest: lastq.widest, cnt: lastq.cnt};
          end else begin
            btop <= top;
            best <= row_count[ROW_AW-1:0];
            cur  <= '{height: h, widest: aw, cnt: 5'd1};
          end
        end
      end
      SP_CHK: begin
        sptr <= sptr_p1;
        if (sw >= w && (!sfound || sw < bw)) begin
          sfound <= 1'b1;
          bspan  <= sptr[SPAN_IW-1:0];
          bw     <= sw;
          bl     <= span_q.le;
          br     <= span_q.re;
        end
      end
      SP_CARVE: begin
        sptr <= {1'b0, bspan};
        if (bw != w && br == aw) lft <= br - w;
        else lft <= bl;
      end
      A_CHKMAX: begin
        sptr <= 5'd0;
        mx   <= 16'd0;
      end
      MX_RD: if (sptr == cur.cnt) cur.widest <= mx;
      MX_CHK: begin
        sptr <= sptr_p1;
        if (sw > mx) mx <= sw;
      end
      RM_RD: if (!(sptr_p1 < cur.cnt)) cur.cnt <= cur.cnt - 5'd1;
      RM_WR: sptr <= sptr_p1;
      F_ROW_ADV: begin
        top  <= top + row_q.height;
        rptr <= rptr + 7'd1;
      end
      F_ROW_GOT: begin
        cur  <= row_q;
        best <= rptr[ROW_AW-1:0];
        sptr <= 5'd0;
        prev <= '0;
        lft  <= rq.item_left;
        rgt  <= rq.item_left + rq.item_width;
      end
      F_SP_CHK: begin
        if (span_q.re <= lft) begin
          prevq <= span_q;
          prev  <= sptr[SPAN_IW-1:0];
          sptr  <= sptr_p1;
        end else begin
          itq <= span_q;
          if (sptr == 5'd0) prevq <= span_q;
        end
      end
      F_MERGE: begin
        if (c1) begin
          rgt <= merge_r;
          lft <= prevq.le;
        end else if (itfit) begin
          rgt <= itq.re;
        end else begin
          bspan <= sptr[SPAN_IW-1:0];
          sptr  <= cur.cnt;
        end
      end
      IN_RD: if (!(sptr > {1'b0, bspan})) cur.cnt <= cur.cnt + 5'd1;
      IN_WR: sptr <= sptr_m1;
      default: ;
    endcase
  end

  // result beat
  always_ff @(posedge clk) begin
    unique case (state)
      A_WB:   rsp <= '{granted: 1'b1, rect_left: lft, rect_top: btop,
                       rect_width: w, rect_height: h};
      S_OK:   rsp <= '{granted: 1'b1, default: '0};
      S_FAIL: rsp <= '0;
      default: ;
    endcase
  end

  `ASSERT_CLK(a_rows_bounded, row_count <= 7'(MAX_ROWS), "row count beyond table")
  `ASSERT_CLK(a_done_idle, done |-> !busy, "result beat while busy")
  `ASSERT_CLK(a_accept, start && !busy |=> busy && !done, "accepted item not taken up")
  `ASSERT_NEVER(a_fail_zero, done && !rsp.granted && (rsp.rect_left != 16'd0 || rsp.rect_top != 16'd0 || rsp.rect_width != 16'd0 || rsp.rect_height != 16'd0), "refused result not zero")

endmodule

/* test/shelf_rect_allocator_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shelf_rect_allocator_test
// Self-checking bench for the shelf allocator: directed corner cases, row and
// span table overflow, then mixed allocate/free traffic over several atlas
// sizes, with each result checked against an in-bench shelf predictor.
// ---------------------------------------------------------------------------
module shelf_rect_allocator_test;
  import sra_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int unsigned M16 = 32'hFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  shelf_rect_allocator DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shelf predictor state
  int unsigned atlas_w, atlas_h, n_rows, height_left;
  int unsigned row_h[MAX_ROWS], row_widest[MAX_ROWS], row_spans[MAX_ROWS];
  int unsigned gap_l[MAX_ROWS][MAX_SPANS], gap_r[MAX_ROWS][MAX_SPANS];

  rsp_t expected_rects[$];
  rsp_t live_rects[$];   // granted allocations, candidates for freeing
  int mismatches = 0;
  int n_sent = 0, n_checked = 0, n_granted = 0, n_configs = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  function automatic int unsigned gap_width(int unsigned r, int unsigned i);
    return (gap_r[r][i] - gap_l[r][i]) & M16;
  endfunction

  function automatic void drop_gap(int unsigned r, int unsigned i);
    for (int unsigned k = i; k + 1 < row_spans[r]; k++) begin
      gap_l[r][k] = gap_l[r][k+1];
      gap_r[r][k] = gap_r[r][k+1];
    end
    row_spans[r]--;
  endfunction

  function automatic rsp_t place_rect(int unsigned w, int unsigned h);
    rsp_t o;
    bit hit;
    int unsigned r, best, btop, match, top, last, diff, i, bgap, bw, left, m, gw;
    o = '0;
    hit = 0; best = 0; btop = 0; match = 0; top = 0;
    for (r = 0; r < n_rows; r++) begin
      if (row_widest[r] >= w && row_h[r] >= h && (!hit || row_h[r] < match)) begin
        hit = 1; best = r; btop = top; match = row_h[r];
        if (row_h[r] == h) break;
      end
      top = (top + row_h[r]) & M16;
    end
    if (!hit && n_rows > 0) begin
      last = n_rows - 1;
      if (row_widest[last] >= w) begin
        diff = (h - row_h[last]) & M16;
        if ((diff <= GROW_LIMIT || height_left < h) && diff <= height_left) begin
          btop = (top - row_h[last]) & M16;
          height_left = (height_left - diff) & M16;
          row_h[last] = h;
          best = last;
          hit = 1;
        end
      end
    end
    if (!hit) begin
      if (height_left < h || n_rows >= MAX_ROWS || atlas_w < w) return o;
      height_left -= h;
      btop = top;
      best = n_rows;
      row_h[best] = h;
      row_widest[best] = atlas_w;
      row_spans[best] = 1;
      gap_l[best][0] = 0;
      gap_r[best][0] = atlas_w;
      n_rows++;
    end
    hit = 0; bgap = 0; bw = 0;
    for (i = 0; i < row_spans[best]; i++) begin
      gw = gap_width(best, i);
      if (gw >= w && (!hit || gw < bw)) begin
        hit = 1; bgap = i; bw = gw;
      end
    end
    if (!hit) return o;
    left = gap_l[best][bgap];
    if (bw == w) drop_gap(best, bgap);
    else if (gap_r[best][bgap] == atlas_w) begin
      gap_r[best][bgap] = (gap_r[best][bgap] - w) & M16;
      left = gap_r[best][bgap];
    end else gap_l[best][bgap] = (left + w) & M16;
    if (bw == row_widest[best]) begin
      m = 0;
      for (i = 0; i < row_spans[best]; i++)
        if (gap_width(best, i) > m) m = gap_width(best, i);
      row_widest[best] = m;
    end
    o.granted = 1'b1;
    o.rect_left = left[15:0];
    o.rect_top = btop[15:0];
    o.rect_width = w[15:0];
    o.rect_height = h[15:0];
    return o;
  endfunction

  function automatic rsp_t release_rect(int unsigned w, int unsigned left, int unsigned ftop);
    rsp_t o;
    int unsigned r, top, right, cnt, it, prv, k, d;
    o = '0;
    r = 0; top = 0; it = 0; prv = 0;
    while (r < n_rows && top != ftop) begin
      top = (top + row_h[r]) & M16;
      r++;
    end
    if (r >= n_rows) return o;
    right = (left + w) & M16;
    cnt = row_spans[r];
    while (it < cnt && gap_r[r][it] <= left) begin
      prv = it;
      it++;
    end
    if (cnt > 0 && gap_r[r][prv] == left) begin
      if (it < cnt && gap_l[r][it] == right) begin
        right = gap_r[r][it];
        drop_gap(r, it);
      end
      gap_r[r][prv] = right;
      left = gap_l[r][prv];
    end else if (it < cnt && gap_l[r][it] == right) begin
      gap_l[r][it] = left;
      right = gap_r[r][it];
    end else begin
      if (cnt >= MAX_SPANS) return o;
      for (k = cnt; k > it; k--) begin
        gap_l[r][k] = gap_l[r][k-1];
        gap_r[r][k] = gap_r[r][k-1];
      end
      gap_l[r][it] = left;
      gap_r[r][it] = right;
      row_spans[r] = cnt + 1;
    end
    d = (right - left) & M16;
    if (d > row_widest[r]) row_widest[r] = d;
    if (row_widest[r] == atlas_w && r + 1 == n_rows) begin
      do begin
        height_left = (height_left + row_h[n_rows-1]) & M16;
        n_rows--;
      end while (n_rows > 0 && row_widest[n_rows-1] == atlas_w);
    end
    o.granted = 1'b1;
    return o;
  endfunction

  function automatic rsp_t predict_request(req_t q);
    if (q.item_width == 0 || q.item_height == 0) return '0;
    if (q.req_type == REQ_ALLOC) return place_rect(q.item_width, q.item_height);
    return release_rect(q.item_width, q.item_left, q.item_top);
  endfunction

  // one beat on the command side; start stays high if the next call follows at once
  task automatic send_request(req_t q);
    rsp_t e;
    if (!start) start <= 1'b1;
    req <= q;
    do @(posedge clk); while (busy);
    e = predict_request(q);
    expected_rects.push_back(e);
    n_sent++;
    if (q.req_type == REQ_ALLOC && e.granted) live_rects.push_back(e);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_alloc(int unsigned w, int unsigned h);
    req_t q;
    q = '0;
    q.req_type = REQ_ALLOC;
    q.item_width = w[15:0];
    q.item_height = h[15:0];
    q.item_left = 16'($urandom);
    q.item_top = 16'($urandom);
    send_request(q);
  endtask

  task automatic send_free(int unsigned w, int unsigned h, int unsigned l, int unsigned t);
    req_t q;
    q.req_type = REQ_FREE;
    q.item_width = w[15:0];
    q.item_height = h[15:0];
    q.item_left = l[15:0];
    q.item_top = t[15:0];
    send_request(q);
  endtask

  task automatic free_live(int idx);
    rsp_t v;
    v = live_rects[idx];
    live_rects.delete(idx);
    send_free(v.rect_width, v.rect_height, v.rect_left, v.rect_top);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [15:0] value);
    if (start) start <= 1'b0;
    while (expected_rects.size() > 0 || busy) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'd4 * REG_ATLAS_W) atlas_w = 32'(value);
    else atlas_h = 32'(value);
    n_rows = 0;
    height_left = atlas_h;
    live_rects.delete();
    n_configs++;
  endtask

  task automatic set_atlas(int unsigned w, int unsigned h);
    write_reg(3'd4 * REG_ATLAS_W, w[15:0]);
    write_reg(3'd4 * REG_ATLAS_H, h[15:0]);
  endtask

  // result beats: compared field by field with the oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && done) begin
      if (expected_rects.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", rsp);
      end else begin
        e = expected_rects.pop_front();
        n_checked++;
        if (e.granted) n_granted++;
        if (rsp.granted !== e.granted || rsp.rect_left !== e.rect_left ||
            rsp.rect_top !== e.rect_top || rsp.rect_width !== e.rect_width ||
            rsp.rect_height !== e.rect_height) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %p, got %p", n_checked, e, rsp);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    set_atlas(1024, 1024);
    send_alloc(0, 5);                      // zero width
    send_free(7, 0, 0, 0);                 // zero height
    send_alloc(65535, 65535);              // cannot fit anywhere
    send_alloc(100, 16);                   // opens row 0
    send_alloc(100, 16);                   // exact height match
    send_alloc(50, 12);                    // shorter item in taller row
    send_alloc(200, 19);                   // grows last row by 3
    send_alloc(200, 40);                   // new row
    send_alloc(1024, 40);                  // too wide for any span, new row
    send_free(10, 5, 0, 3);                // top is not a row start
    send_free(100, 16, 924, 0);            // touching right edge
    send_free(100, 16, 824, 0);
    send_free(1024, 40, 0, 59);            // trailing row freed, popped
    send_alloc(1024, 900);                 // no row wide enough, new row
    send_free(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_atlas(65535, 65535);
    send_alloc(65535, 65535);              // full-size row and span
    send_free(65535, 65535, 0, 0);
    send_alloc(1, 1);
    set_atlas(1, 1);
    send_alloc(1, 1);
    send_alloc(1, 1);
    send_alloc(2, 1);
  endtask

  task automatic test_row_table_full();
    set_atlas(16, 65535);
    for (int i = 0; i < MAX_ROWS + 2; i++) send_alloc(16, 1);
  endtask

  task automatic test_span_table_full();
    set_atlas(80, 64);
    for (int i = 0; i < 40; i++) send_alloc(2, 8);
    for (int i = 0; i < 20; i++) send_free(2, 8, 4 * i + 1 - (i % 2) + (i % 2), 0);
    for (int i = 0; i < 20; i++) send_free(2, 8, 4 * i, 0);
  endtask

  task automatic test_mixed_traffic(int unsigned n);
    int unsigned roll, wmax;
    req_t q;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      wmax = (atlas_w / 3 > 0) ? atlas_w / 3 : 1;
      if (roll < 58) begin
        if ($urandom_range(3) == 0) send_alloc($urandom_range(1, atlas_w + 2),
                                                $urandom_range(1, 64));
        else send_alloc($urandom_range(1, wmax), $urandom_range(1, 24));
      end else if (roll < 92 && live_rects.size() > 0)
        free_live($urandom_range(live_rects.size() - 1));
      else begin
        q = '0;
        q.req_type = 1'($urandom_range(1));
        q.item_width = 16'($urandom);
        q.item_height = 16'($urandom);
        q.item_left = 16'($urandom);
        q.item_top = 16'($urandom);
        send_request(q);
      end
    end
  endtask

  task automatic test_random_phases();
    int unsigned dims[5] = '{1, 64, 300, 1024, 65535};
    int pct[3] = '{22, 54, 0};
    for (int p = 0; p < 3; p++) begin
      idle_pct = pct[p];
      for (int c = 0; c < 3; c++) begin
        set_atlas(dims[$urandom_range(1, 4)], dims[$urandom_range(1, 3)]);
        test_mixed_traffic(128);
      end
    end
    set_atlas(65535, 1);
    test_mixed_traffic(30);
  endtask

  initial begin
    atlas_w = RST_DIM;
    atlas_h = RST_DIM;
    n_rows = 0;
    height_left = RST_DIM;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 22;
    test_directed();
    test_row_table_full();
    test_span_table_full();
    test_random_phases();
    if (start) start <= 1'b0;
    while (expected_rects.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d requests sent, %0d results checked (%0d granted), %0d register writes",
             n_sent, n_checked, n_granted, n_configs);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
